### design/fmte_pkg.sv
// Package for the fuzzy membership table engine.
// Holds field widths, command, status and register index codes.
// No dependencies; fmte_channels and the top level use it.
package fmte_pkg;

   localparam int CMD_W      = 3;
   localparam int PIDX_W     = 6;
   localparam int X_W        = 16;
   localparam int DEG_W      = 16;
   localparam int STAT_W     = 2;
   localparam int PCNT_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [DEG_W-1:0] DEGREE_ONE = 16'd32768;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLAMP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEFUZZ = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd2;

endpackage

### design/fmte_channels.sv
// Valid/ready channel interfaces for the command and result transactions.
// Depends on fmte_pkg for the field widths.
interface fmte_req_if;
   logic                              valid;
   logic                              ready;
   logic [fmte_pkg::CMD_W-1:0]        cmd;
   logic [fmte_pkg::PIDX_W-1:0]       point_index;
   logic signed [fmte_pkg::X_W-1:0]   x_value;
   logic [fmte_pkg::DEG_W-1:0]        degree;

   modport source (output valid, output cmd, output point_index, output x_value,
                   output degree, input ready);
   modport sink   (input valid, input cmd, input point_index, input x_value,
                   input degree, output ready);
endinterface

interface fmte_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fmte_pkg::DEG_W-1:0]        degree_out;
   logic signed [fmte_pkg::X_W-1:0]   centroid_out;
   logic [fmte_pkg::STAT_W-1:0]       status;

   modport source (output valid, output degree_out, output centroid_out,
                   output status, input ready);
   modport sink   (input valid, input degree_out, input centroid_out,
                   input status, output ready);
endinterface

### design/fmte_muldiv.sv
// Iterative unit that computes floor(a*b/d) and the remainder, one bit of a
// at a time (an add state, then a subtract state), with b no larger than d. Depends on no package items.
module fmte_muldiv #(
   parameter int DW = 28
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [15:0]   a,
   input  logic [DW-1:0] b,
   input  logic [DW-1:0] d,
   output logic          done,
   output logic [15:0]   q,
   output logic [DW-1:0] rem
);

   typedef enum logic [1:0] {MD_IDLE, MD_ADD, MD_SUB} md_state_type;

   md_state_type      state_ff;
   logic [3:0]        bit_ff;
   logic [15:0]       a_ff;
   logic [DW-1:0]     b_ff;
   logic [DW-1:0]     d_ff;
   logic [DW+1:0]     acc_ff;
   logic [15:0]       q_ff;
   logic              done_ff;
   logic [DW+1:0]     d1;
   logic [DW+1:0]     d2;

   assign d1 = {2'b00, d_ff};
   assign d2 = {1'b0, d_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
         bit_ff   <= '0;
      end else begin
         case (state_ff)
            MD_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  a_ff     <= a;
                  b_ff     <= b;
                  d_ff     <= d;
                  acc_ff   <= '0;
                  q_ff     <= '0;
                  bit_ff   <= '0;
                  state_ff <= MD_ADD;
               end
            end
            MD_ADD: begin
               done_ff  <= 1'b0;
               acc_ff   <= {acc_ff[DW:0], 1'b0} + (a_ff[15] ? {2'b00, b_ff} : '0);
               a_ff     <= {a_ff[14:0], 1'b0};
               q_ff     <= {q_ff[14:0], 1'b0};
               state_ff <= MD_SUB;
            end
            MD_SUB: begin
               if (acc_ff >= d2) begin
                  acc_ff <= acc_ff - d2;
                  q_ff   <= q_ff + 16'd2;
               end else if (acc_ff >= d1) begin
                  acc_ff <= acc_ff - d1;
                  q_ff   <= q_ff + 16'd1;
               end
               if (bit_ff == 4'd15) begin
                  done_ff  <= 1'b1;
                  state_ff <= MD_IDLE;
               end else begin
                  done_ff  <= 1'b0;
                  bit_ff   <= bit_ff + 4'd1;
                  state_ff <= MD_ADD;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= MD_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign q    = q_ff;
   assign rem  = acc_ff[DW-1:0];

endmodule

### design/fuzzy_membership_table_engine.sv
// Top level of the fuzzy membership table engine: degree table memory,
// command sequencer and configuration registers.
// Depends on fmte_pkg, fmte_channels and fmte_muldiv.
//
// Usage: commands arrive as transactions on req_ch and each one yields exactly
// one result transaction on rsp_ch. The user must write the configuration
// registers on the csr_ port only while the engine is idle; the block itself
// does not enforce this. The engine takes one command at a time; req_ch.ready
// is high only while no command is in progress. A write point or unknown
// command goes straight to its result; clear zeroes each table entry in turn,
// clamp reads and rewrites each entry, evaluate makes two passes of the shared
// multiply-divide unit, and defuzzify reads the n points in use, one table
// read per cycle, then makes one pass. The table has a single read port. The
// next command is accepted once the engine is back in idle. After reset the
// table is cleared one entry per cycle while req_ch.ready stays low. A finished
// result sits in an output register; the next command is accepted while it
// waits, and if the receiver still stalls when that command finishes, the
// engine holds in place until rsp_ch.ready returns.
module fuzzy_membership_table_engine #(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   fmte_req_if.sink                        req_ch,
   fmte_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [fmte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fmte_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fmte_pkg::*;

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int SYW = 16 + AW;
   localparam int DW  = 16 + 2 * AW;
   localparam logic [AW:0] CNT_LAST = (AW+1)'(MAX_POINTS - 1);
   localparam logic [AW:0] CNT_END  = (AW+1)'(MAX_POINTS);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_EV_CHK, S_EV_DIV1, S_EV_RD0, S_EV_RD1, S_EV_RD2,
      S_EV_DIV2, S_CLAMP, S_ZERO, S_DF_SUM, S_DF_DEN, S_DF_GO, S_DF_DIV, S_DONE
   } state_type;

   state_type                state_ff;
   logic [AW:0]              cnt_ff;

   logic signed [X_W-1:0]    range_min_ff;
   logic signed [X_W-1:0]    range_max_ff;
   logic [PCNT_W-1:0]        pcount_ff;
   logic signed [X_W:0]      span_in;
   logic signed [X_W:0]      span_ff;
   logic [15:0]              span_abs_ff;
   logic [AW-1:0]            nm1_in;
   logic [AW-1:0]            nm1_ff;

   logic [DEG_W-1:0]         mem [MAX_POINTS];
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [DEG_W-1:0]         mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [DEG_W-1:0]         rd_data_ff;

   logic signed [X_W-1:0]    x_ff;
   logic [DEG_W-1:0]         deg_ff;
   logic [AW-1:0]            idx_ff;
   logic [15:0]              rem_ff;
   logic [DEG_W-1:0]         y0_ff;
   logic                     up_ff;
   logic                     up;
   logic signed [X_W:0]      dx;
   logic                     ev_ok;

   logic                     v1_ff;
   logic                     v2_ff;
   logic [AW-1:0]            k1_ff;
   logic [AW+15:0]           prod_ff;
   logic [SYW-1:0]           sy_ff;
   logic [DW-1:0]            siy_ff;
   logic [DW-1:0]            den_ff;
   logic                     df_more;

   logic                     md_start;
   logic [15:0]              md_a;
   logic [DW-1:0]            md_b;
   logic [DW-1:0]            md_d;
   logic                     md_done;
   logic [15:0]              md_q;
   logic [DW-1:0]            md_rem;

   logic signed [17:0]       cen_base;
   logic signed [17:0]       cen_fix;

   logic [DEG_W-1:0]         deg_res_ff;
   logic signed [X_W-1:0]    cen_res_ff;
   logic [STAT_W-1:0]        stat_res_ff;
   logic                     rsp_valid_ff;
   logic [DEG_W-1:0]         rsp_deg_ff;
   logic signed [X_W-1:0]    rsp_cen_ff;
   logic [STAT_W-1:0]        rsp_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= 16'sd0;
         range_max_ff <= 16'sd32767;
         pcount_ff    <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_MIN:   range_min_ff <= csr_wdata;
            CSR_RANGE_MAX:   range_max_ff <= csr_wdata;
            CSR_POINT_COUNT: pcount_ff    <= csr_wdata[PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      span_in = {range_max_ff[X_W-1], range_max_ff} - {range_min_ff[X_W-1], range_min_ff};
      if (pcount_ff < 7'd2) begin
         nm1_in = AW'(1);
      end else if (int'(pcount_ff) > MAX_POINTS) begin
         nm1_in = AW'(MAX_POINTS - 1);
      end else begin
         nm1_in = AW'(pcount_ff - 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      span_abs_ff <= span_in[X_W] ? 16'(-span_in) : span_in[15:0];
      nm1_ff      <= nm1_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign dx      = {x_ff[X_W-1], x_ff} - {range_min_ff[X_W-1], range_min_ff};
   assign ev_ok   = !span_ff[X_W] && (span_ff != '0) && !dx[X_W] && (dx < span_ff);
   assign df_more = cnt_ff <= {1'b0, nm1_ff};
   assign up      = rd_data_ff >= y0_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && req_ch.cmd == CMD_WRITE
                && int'(req_ch.point_index) < MAX_POINTS) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(req_ch.point_index);
               mem_wdata = (req_ch.degree > DEGREE_ONE) ? DEGREE_ONE : req_ch.degree;
            end
         end
         S_INIT, S_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
         end
         S_CLAMP: begin
            mem_raddr = cnt_ff[AW-1:0];
            mem_we    = cnt_ff != '0;
            mem_waddr = AW'(cnt_ff - 1'b1);
            mem_wdata = (rd_data_ff > deg_ff) ? deg_ff : rd_data_ff;
         end
         S_EV_RD0: mem_raddr = idx_ff;
         S_EV_RD1: mem_raddr = AW'(idx_ff + 1'b1);
         S_DF_SUM: mem_raddr = cnt_ff[AW-1:0];
         default: ;
      endcase
   end

   always_comb begin
      md_start = 1'b0;
      md_a     = '0;
      md_b     = '0;
      md_d     = '0;
      case (state_ff)
         S_EV_CHK: begin
            md_start = ev_ok;
            md_a     = 16'(nm1_ff);
            md_b     = DW'(dx[15:0]);
            md_d     = DW'(span_ff[15:0]);
         end
         S_EV_RD2: begin
            md_start = 1'b1;
            md_a     = up ? rd_data_ff - y0_ff : y0_ff - rd_data_ff;
            md_b     = DW'(rem_ff);
            md_d     = DW'(span_ff[15:0]);
         end
         S_DF_GO: begin
            md_start = 1'b1;
            md_a     = span_abs_ff;
            md_b     = siy_ff;
            md_d     = den_ff;
         end
         default: ;
      endcase
   end

   fmte_muldiv #(.DW(DW)) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (md_d),
      .done  (md_done),
      .q     (md_q),
      .rem   (md_rem)
   );

   // The centroid is rounded toward zero from lo +/- (q + rem/den).
   always_comb begin
      if (!span_ff[X_W]) begin
         cen_base = 18'(range_min_ff) + 18'(md_q);
         cen_fix  = (md_rem != '0 && cen_base < 0) ? cen_base + 18'sd1 : cen_base;
      end else begin
         cen_base = 18'(range_min_ff) - 18'(md_q);
         cen_fix  = (md_rem != '0 && cen_base > 0) ? cen_base - 18'sd1 : cen_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         if (rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_ch.valid) begin
                  x_ff        <= req_ch.x_value;
                  deg_ff      <= req_ch.degree;
                  deg_res_ff  <= '0;
                  cen_res_ff  <= '0;
                  stat_res_ff <= ST_OK;
                  cnt_ff      <= '0;
                  sy_ff       <= '0;
                  siy_ff      <= '0;
                  v1_ff       <= 1'b0;
                  v2_ff       <= 1'b0;
                  case (req_ch.cmd)
                     CMD_EVAL:   state_ff <= S_EV_CHK;
                     CMD_CLAMP:  state_ff <= S_CLAMP;
                     CMD_DEFUZZ: state_ff <= S_DF_SUM;
                     CMD_CLEAR:  state_ff <= S_ZERO;
                     default:    state_ff <= S_DONE;
                  endcase
               end
            end
            S_EV_CHK: begin
               if (ev_ok) begin
                  state_ff <= S_EV_DIV1;
               end else begin
                  stat_res_ff <= ST_RANGE;
                  state_ff    <= S_DONE;
               end
            end
            S_EV_DIV1: begin
               if (md_done) begin
                  idx_ff   <= md_q[AW-1:0];
                  rem_ff   <= md_rem[15:0];
                  state_ff <= S_EV_RD0;
               end
            end
            S_EV_RD0: state_ff <= S_EV_RD1;
            S_EV_RD1: begin
               y0_ff    <= rd_data_ff;
               state_ff <= S_EV_RD2;
            end
            S_EV_RD2: begin
               up_ff    <= up;
               state_ff <= S_EV_DIV2;
            end
            S_EV_DIV2: begin
               if (md_done) begin
                  deg_res_ff <= up_ff ? y0_ff + md_q
                                      : y0_ff - md_q - 16'(md_rem != '0);
                  state_ff   <= S_DONE;
               end
            end
            S_CLAMP: begin
               if (cnt_ff == CNT_END) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ZERO: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DF_SUM: begin
               if (df_more) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               v1_ff <= df_more;
               k1_ff <= cnt_ff[AW-1:0];
               v2_ff <= v1_ff;
               if (v1_ff) begin
                  sy_ff   <= sy_ff + SYW'(rd_data_ff);
                  prod_ff <= {16'd0, k1_ff} * {{AW{1'b0}}, rd_data_ff};
               end
               if (v2_ff) begin
                  siy_ff <= siy_ff + DW'(prod_ff);
               end
               if (!df_more && !v1_ff && !v2_ff) begin
                  state_ff <= S_DF_DEN;
               end
            end
            S_DF_DEN: begin
               den_ff <= {{SYW{1'b0}}, nm1_ff} * {{AW{1'b0}}, sy_ff};
               if (sy_ff == '0) begin
                  stat_res_ff <= ST_EMPTY;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= S_DF_GO;
               end
            end
            S_DF_GO: state_ff <= S_DF_DIV;
            S_DF_DIV: begin
               if (md_done) begin
                  cen_res_ff <= cen_fix[15:0];
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_deg_ff   <= deg_res_ff;
                  rsp_cen_ff   <= cen_res_ff;
                  rsp_stat_ff  <= stat_res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = state_ff == S_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.degree_out   = rsp_deg_ff;
   assign rsp_ch.centroid_out = rsp_cen_ff;
   assign rsp_ch.status       = rsp_stat_ff;

endmodule

### tb/sv/membership_checker.sv
`timescale 1ns / 1ps
// Checker for the fuzzy membership table engine: watches the command, result and
// register ports, predicts each result from its own copy of the degree table and
// compares them field by field. Depends on fmte_pkg and fmte_channels.
module membership_checker #(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   fmte_req_if                             req_ch,
   fmte_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [fmte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fmte_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              results_seen,
   output int                              failures
);
   import fmte_pkg::*;

   typedef struct packed {
      logic [DEG_W-1:0]  degree_out;
      logic [X_W-1:0]    centroid_out;
      logic [STAT_W-1:0] status;
   } outcome_type;

   logic [DEG_W-1:0]        membership [MAX_POINTS];
   logic signed [X_W-1:0]   x_first;
   logic signed [X_W-1:0]   x_last;
   logic [PCNT_W-1:0]       points_cfg;
   outcome_type             pending_outcomes [$];
   int                      mismatch_count;
   int                      pending;

   assign failures = mismatch_count + pending;

   function automatic outcome_type table_response(input logic [CMD_W-1:0] cmd,
                                                  input logic [PIDX_W-1:0] pidx,
                                                  input logic signed [X_W-1:0] xv,
                                                  input logic [DEG_W-1:0] deg);
      outcome_type res;
      longint lo, span, n, t, i, r, acc, sy, siy, den, num;
      res = '0;
      lo = x_first;
      span = longint'(x_last) - lo;
      n = (points_cfg < 2) ? 2 : ((points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg);
      case (cmd)
         CMD_WRITE: begin
            if (int'(pidx) < MAX_POINTS) begin
               membership[pidx] = (deg > DEGREE_ONE) ? DEGREE_ONE : deg;
            end
         end
         CMD_EVAL: begin
            t = (longint'(xv) - lo) * (n - 1);
            if (span <= 0 || t < 0 || t >= span * (n - 1)) begin
               res.status = ST_RANGE;
            end else begin
               i = t / span;
               r = t - i * span;
               acc = longint'(membership[i]) * (span - r) + longint'(membership[i + 1]) * r;
               res.degree_out = DEG_W'(acc / span);
            end
         end
         CMD_CLAMP: begin
            for (int k = 0; k < MAX_POINTS; k++) begin
               if (membership[k] > deg) membership[k] = deg;
            end
         end
         CMD_DEFUZZ: begin
            sy = 0;
            siy = 0;
            for (int k = 0; k < n; k++) begin
               sy += longint'(membership[k]);
               siy += longint'(k) * longint'(membership[k]);
            end
            if (sy == 0) begin
               res.status = ST_EMPTY;
            end else begin
               den = (n - 1) * sy;
               num = lo * den + span * siy;
               res.centroid_out = X_W'(num / den);
            end
         end
         CMD_CLEAR: begin
            for (int k = 0; k < MAX_POINTS; k++) membership[k] = '0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      logic        bad;
      if (reset) begin
         for (int k = 0; k < MAX_POINTS; k++) membership[k] = '0;
         x_first = '0;
         x_last = 16'sd32767;
         points_cfg = 7'd64;
         pending_outcomes.delete();
         mismatch_count = 0;
         results_seen <= 0;
         pending <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.degree_out, rsp_ch.centroid_out, rsp_ch.status};
            results_seen <= results_seen + 1;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: result transaction with nothing expected, %s %0d %0d %0d",
                        $time, "got degree, centroid and status", got.degree_out,
                        $signed(got.centroid_out), got.status);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               bad = 1'b0;
               if (got.degree_out !== want.degree_out) begin
                  $display("%0t: degree_out expected %0d, got %0d",
                           $time, want.degree_out, got.degree_out);
                  bad = 1'b1;
               end
               if (got.centroid_out !== want.centroid_out) begin
                  $display("%0t: centroid_out expected %0d, got %0d",
                           $time, $signed(want.centroid_out), $signed(got.centroid_out));
                  bad = 1'b1;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                  bad = 1'b1;
               end
               if (bad) mismatch_count++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_MIN:   x_first = csr_wdata[X_W-1:0];
               CSR_RANGE_MAX:   x_last = csr_wdata[X_W-1:0];
               CSR_POINT_COUNT: points_cfg = csr_wdata[PCNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_outcomes.push_back(table_response(req_ch.cmd, req_ch.point_index,
                                                      req_ch.x_value, req_ch.degree));
         end
         pending <= pending_outcomes.size();
      end
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the fuzzy membership table engine testbench: clock, reset, command stimulus,
// result back-pressure, register settings and the final verdict.
// Depends on fmte_pkg, fmte_channels, the engine itself and membership_checker.
module testbench;
   import fmte_pkg::*;

   localparam int MAX_POINTS = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_LEN = 400;
   localparam int PHASES = 13;
   localparam int ITEMS_PER_PHASE = 100;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    results_seen;
   int                    failures;
   int                    issued = 0;
   int                    csr_writes = 0;
   int                    setting_changes = 0;
   int                    cmd_hits [8];
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    hold_requests = 0;
   int                    hold_served = 0;
   int                    hold_count = 0;
   int                    cycle_count = 0;
   int                    cur_min = 0;
   int                    cur_max = 32767;
   int                    cur_n = 64;

   fmte_req_if req_ch ();
   fmte_rsp_if rsp_ch ();

   fuzzy_membership_table_engine #(.MAX_POINTS(MAX_POINTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   membership_checker #(.MAX_POINTS(MAX_POINTS)) table_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .results_seen (results_seen),
      .failures     (failures)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d of %0d results received.",
                  cycle_count, results_seen, issued);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // The receiver either follows the current stall rate or holds off for a long stretch.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            rsp_ch.ready <= 1'b0;
            if (hold_count == HOLD_LEN - 1) begin
               hold_count = 0;
               hold_served++;
            end else begin
               hold_count++;
            end
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int pidx, input int xv,
                           input int deg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.point_index <= pidx[PIDX_W-1:0];
      req_ch.x_value <= xv[X_W-1:0];
      req_ch.degree <= deg[DEG_W-1:0];
      do @(posedge clock); while (!req_ch.ready);
      issued++;
      cmd_hits[cmd]++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (results_seen != issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic configure(input int lo, input int hi, input int count);
      settle();
      write_csr(CSR_RANGE_MIN, lo);
      write_csr(CSR_RANGE_MAX, hi);
      write_csr(CSR_POINT_COUNT, count);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_min = lo;
      cur_max = hi;
      cur_n = count & 127;
      cur_n = (cur_n < 2) ? 2 : ((cur_n > MAX_POINTS) ? MAX_POINTS : cur_n);
      setting_changes++;
   endtask

   function automatic int pick_degree();
      case ($urandom_range(9))
         0: return 0;
         1: return int'(DEGREE_ONE);
         2: return $urandom_range(65535, 32769);
         3: return $urandom_range(255);
         default: return $urandom_range(32767, 1);
      endcase
   endfunction

   task automatic random_config();
      int lo, hi, count, choice;
      lo = int'($urandom_range(65535)) - 32768;
      choice = $urandom_range(9);
      if (choice < 6 && lo < 32767) hi = lo + int'($urandom_range(32767 - lo, 1));
      else if (choice < 8) hi = (lo + 200 > 32767) ? 32767 : lo + int'($urandom_range(200, 1));
      else if (choice == 8) hi = int'($urandom_range(65535)) - 32768;
      else hi = lo;
      choice = $urandom_range(9);
      if (choice < 7) count = $urandom_range(MAX_POINTS, 2);
      else if (choice == 7) count = 2;
      else if (choice == 8) count = MAX_POINTS;
      else count = $urandom_range(127);
      configure(lo, hi, count + int'($urandom_range(511) << PCNT_W));
   endtask

   task automatic random_cmd();
      int pick, xv, pidx;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_WRITE;
      else if (pick < 72) cmd = CMD_EVAL;
      else if (pick < 84) cmd = CMD_DEFUZZ;
      else if (pick < 90) cmd = CMD_CLAMP;
      else if (pick < 94) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      pick = $urandom_range(99);
      if (cur_max > cur_min && pick < 20)
         xv = cur_min + ($urandom_range(cur_n - 1) * (cur_max - cur_min)) / (cur_n - 1);
      else if (cur_max > cur_min && pick < 85)
         xv = cur_min + int'($urandom_range(cur_max - cur_min));
      else
         xv = int'($urandom_range(65535)) - 32768;
      pidx = ($urandom_range(99) < 85) ? $urandom_range(cur_n - 1) : $urandom_range(63);
      send_cmd(cmd, pidx, xv, pick_degree());
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.point_index = '0;
      req_ch.x_value = '0;
      req_ch.degree = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      foreach (cmd_hits[k]) cmd_hits[k] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      send_cmd(CMD_EVAL, 0, 0, 0);
      send_cmd(CMD_WRITE, 0, 0, int'(DEGREE_ONE));
      send_cmd(CMD_WRITE, 63, 0, 65535);
      send_cmd(CMD_WRITE, 1, 0, 12345);
      send_cmd(CMD_EVAL, 0, -32768, 0);
      send_cmd(CMD_EVAL, 0, 32767, 0);
      send_cmd(CMD_EVAL, 0, 32766, 0);
      send_cmd(CMD_EVAL, 0, 0, 0);
      send_cmd(CMD_EVAL, 0, 300, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      send_cmd(CMD_CLAMP, 0, 0, 16384);
      send_cmd(CMD_EVAL, 0, 100, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      send_cmd(CMD_SPARE_LO, 63, -1, 65535);
      send_cmd(CMD_SPARE_HI, 21, 12345, 32768);
      configure(-32768, 32767, 0);
      send_cmd(CMD_EVAL, 0, 0, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      send_cmd(CMD_EVAL, 0, -32768, 0);
      configure(200, 200, 127);
      send_cmd(CMD_EVAL, 0, 200, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      configure(300, -300, MAX_POINTS);
      send_cmd(CMD_EVAL, 0, 0, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);
      send_cmd(CMD_CLEAR, 0, 0, 0);
      send_cmd(CMD_DEFUZZ, 0, 0, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(-32768, 32767, MAX_POINTS);
            1: configure(-32768, 32767, 1);
            2: configure(-100, 100, 2);
            3: configure(0, 5, MAX_POINTS);
            default: random_config();
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         if (phase == 4 || phase == 9) begin
            send_idle_pct = 0;
            hold_requests++;
         end
         for (int item = 0; item < ITEMS_PER_PHASE; item++) random_cmd();
      end

      settle();
      repeat (120) @(posedge clock);
      $display("Covered %0d commands: %0d writes, %0d evaluates, %0d clamps, %0d defuzzifies,",
               issued, cmd_hits[CMD_WRITE], cmd_hits[CMD_EVAL], cmd_hits[CMD_CLAMP],
               cmd_hits[CMD_DEFUZZ]);
      $display("%0d clears and %0d unused codes, over %0d range settings (%0d register writes).",
               cmd_hits[CMD_CLEAR], cmd_hits[5] + cmd_hits[6] + cmd_hits[7], setting_changes,
               csr_writes);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
